// File: src/fhm_pkg.sv
// Shared types and constants for the FIFO-queued handoff mutex.
// No dependencies; imported by fhm_ctrl, fhm_datapath and fifo_handoff_mutex.
package fhm_pkg;

    localparam int TASK_COUNT          = 16;
    localparam int TASK_W              = $clog2(TASK_COUNT);
    localparam int QUEUE_DEPTH_DEFAULT = 16;

    typedef enum logic [1:0] {
        CMD_CLEAR  = 2'd0,
        CMD_TRY    = 2'd1,
        CMD_LOCK   = 2'd2,
        CMD_UNLOCK = 2'd3
    } cmd_t;

    typedef struct packed {
        cmd_t              command;
        logic [TASK_W-1:0] task_id;
    } req_t;

    typedef struct packed {
        logic              granted;
        logic              queued;
        logic              rejected;
        logic              woken_valid;
        logic [TASK_W-1:0] woken_task;
        logic              lock_held;
        logic [TASK_W-1:0] holder_task;
    } result_t;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_EXEC = 1'b1
    } state_t;

    typedef struct packed {
        logic capture;
        logic commit;
    } dp_cmd_t;

    typedef struct packed {
        logic out_stall;
    } dp_status_t;

endpackage

// File: src/fhm_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No package dependencies.
module fhm_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// File: src/fhm_ctrl.sv
// Controller FSM: accepts one request, then commits it once the output stage is free.
// Depends on fhm_pkg.
module fhm_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  fhm_pkg::dp_status_t status,
    output fhm_pkg::dp_cmd_t    cmd
);
    import fhm_pkg::*;

    state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                if (!status.out_stall) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_ready     = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_ready     = 1'b1;
                cmd.capture = s_valid;
            end
            ST_EXEC: begin
                cmd.commit = !status.out_stall;
            end
            default: ;
        endcase
    end

endmodule

// File: src/fhm_datapath.sv
// Datapath: lock state, waiter queue pointers and RAM, result register.
// Depends on fhm_pkg and fhm_ram.
module fhm_datapath #(
    parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                aclk,
    input  logic                aresetn,
    input  fhm_pkg::req_t       s_req,
    input  fhm_pkg::dp_cmd_t    cmd,
    output fhm_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output fhm_pkg::result_t    m_result
);
    import fhm_pkg::*;

    localparam int ADDR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(QUEUE_DEPTH - 1);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(QUEUE_DEPTH);

    req_t              req_reg;
    logic              lock_reg, lock_next;
    logic [TASK_W-1:0] owner_reg, owner_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [ADDR_W-1:0] tail_reg, tail_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg;
    result_t           result_reg, result_next;
    logic              wr_en;
    logic [TASK_W-1:0] rd_data;

    function automatic logic [ADDR_W-1:0] next_slot(input logic [ADDR_W-1:0] idx);
        return (idx == LAST_SLOT) ? '0 : idx + 1'b1;
    endfunction

    fhm_ram #(
        .WIDTH(TASK_W),
        .DEPTH(QUEUE_DEPTH)
    ) u_waiters (
        .aclk  (aclk),
        .we    (wr_en),
        .waddr (tail_reg),
        .wdata (req_reg.task_id),
        .raddr (head_reg),
        .rdata (rd_data)
    );

    always_comb begin
        lock_next   = lock_reg;
        owner_next  = owner_reg;
        head_next   = head_reg;
        tail_next   = tail_reg;
        count_next  = count_reg;
        result_next = '0;
        wr_en       = 1'b0;
        unique case (req_reg.command)
            CMD_CLEAR: begin
                lock_next  = 1'b0;
                owner_next = '0;
                head_next  = '0;
                tail_next  = '0;
                count_next = '0;
            end
            CMD_TRY: begin
                if (!lock_reg) begin
                    lock_next           = 1'b1;
                    owner_next          = req_reg.task_id;
                    result_next.granted = 1'b1;
                end
            end
            CMD_LOCK: begin
                if (!lock_reg) begin
                    lock_next           = 1'b1;
                    owner_next          = req_reg.task_id;
                    result_next.granted = 1'b1;
                end else if (count_reg != FULL_CNT) begin
                    wr_en              = cmd.commit;
                    tail_next          = next_slot(tail_reg);
                    count_next         = count_reg + 1'b1;
                    result_next.queued = 1'b1;
                end else begin
                    result_next.rejected = 1'b1;
                end
            end
            CMD_UNLOCK: begin
                if (count_reg != '0) begin
                    lock_next               = 1'b1;
                    owner_next              = rd_data;
                    head_next               = next_slot(head_reg);
                    count_next              = count_reg - 1'b1;
                    result_next.woken_valid = 1'b1;
                    result_next.woken_task  = rd_data;
                end else begin
                    lock_next  = 1'b0;
                    owner_next = '0;
                end
            end
            default: ;
        endcase
        result_next.lock_held   = lock_next;
        result_next.holder_task = lock_next ? owner_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            lock_reg    <= 1'b0;
            owner_reg   <= '0;
            head_reg    <= '0;
            tail_reg    <= '0;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.commit) begin
                lock_reg    <= lock_next;
                owner_reg   <= owner_next;
                head_reg    <= head_next;
                tail_reg    <= tail_next;
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            req_reg <= s_req;
        end
        if (cmd.commit) begin
            result_reg <= result_next;
        end
    end

    assign status.out_stall = m_valid_reg && !m_ready;
    assign m_valid          = m_valid_reg;
    assign m_result         = result_reg;

    // waiters only exist while someone holds the lock
    assert property (@(posedge aclk) disable iff (!aresetn)
        !lock_reg |-> (count_reg == '0))
        else $error("waiter queue not empty while lock is free");

    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= FULL_CNT)
        else $error("waiter count above queue depth");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> $onehot0({result_reg.granted, result_reg.queued,
                                  result_reg.rejected, result_reg.woken_valid}))
        else $error("conflicting result flags");

    assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.commit |=> (result_reg.lock_held == lock_reg) &&
                       (!result_reg.rejected || (count_reg == FULL_CNT)))
        else $error("result does not match committed state");

endmodule

// File: src/fifo_handoff_mutex.sv
// Channel   Dir  Handshake          Payload
// s_        in   s_valid/s_ready    s_req    (command, task_id)
// m_        out  m_valid/m_ready    m_result (granted ... holder_task)
//
// Each request is captured in ST_IDLE, where the head waiter is also read from the
// queue RAM (registered read), and its state update is committed in ST_EXEC.
// The next request is taken while a finished result waits in the output register;
// commit holds while that register is still full and not being taken.
// Synchronous active-low reset frees the lock and empties the queue; no clearing pass.
// Depends on fhm_pkg, fhm_ctrl, fhm_datapath, fhm_ram.
module fifo_handoff_mutex #(
    parameter int QUEUE_DEPTH = fhm_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    output logic             s_ready,
    input  fhm_pkg::req_t    s_req,
    output logic             m_valid,
    input  logic             m_ready,
    output fhm_pkg::result_t m_result
);
    import fhm_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    fhm_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    fhm_datapath #(
        .QUEUE_DEPTH(QUEUE_DEPTH)
    ) u_datapath (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_req    (s_req),
        .cmd      (cmd),
        .status   (status),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_result (m_result)
    );

endmodule
